@@ rtl/ffpa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared types and constants of the first-fit page allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

  // parameter defaults
  localparam int MAX_PAGES_DEF  = 8192;
  localparam int PAGE_BYTES_DEF = 4096;

  // field widths of the stream beats
  localparam int SIZE_W  = 26;
  localparam int INDEX_W = 13;
  localparam int STAT_W  = 2;

  // run header layout: used mark on top, run length below
  localparam int ENTRY_W = 16;
  localparam int LEN_W   = 15;
  localparam logic [LEN_W-1:0] LEN_MAX = 15'h7fff;

  // page position; holds a start page plus a run length without overflow
  localparam int POS_W = 16;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_NEED   = 9'b000001000,
    S_WALK   = 9'b000010000,
    S_SPLIT  = 9'b000100000,
    S_FREAD  = 9'b001000000,
    S_FMERGE = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

endpackage

@@ rtl/first_fit_page_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// first-fit page allocator over a table of run headers kept in one memory
// ----------------------------------------------------------------------------
// steps, allocate: the page count (reciprocal multiply, back multiply, one
//   correction step), a check of the count, one memory read per run header
//   visited, a split write when the picked run is split, then the result
//   handover once the output register is free
// steps, free: header read, then an optional neighbor read and merge
// one request at a time; the next input beat is taken once the result sits
//   in the output register, even while that result still waits for out_tready
// reset: a clearing sweep writes every table entry, one per cycle; no input
//   beat is accepted until it ends
module first_fit_page_allocator #(
  parameter int MAX_PAGES  = ffpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [25:0] size_bytes, [38:26] block_index, [39] zero
  input  logic        in_tuser,   // [0] action (0 allocate, 1 free)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [12:0] alloc_index, [15:13] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  // table address width and division remainder width
  localparam int AW = $clog2(MAX_PAGES);
  localparam int RW = $clog2(PAGE_BYTES) + 1;
  localparam int DCNT_W = 2;

  // reciprocal of the page size, scaled so the quotient is at most one low
  localparam int DIV_SH = ffpa_pkg::SIZE_W + $clog2(PAGE_BYTES);
  localparam int PROD_W = 2 * ffpa_pkg::SIZE_W + 1;
  localparam int BACK_W = ffpa_pkg::SIZE_W + RW;

  localparam logic [ffpa_pkg::POS_W-1:0] LAST_POS  = ffpa_pkg::POS_W'(MAX_PAGES - 1);
  localparam logic [ffpa_pkg::POS_W-1:0] PAGES_POS = ffpa_pkg::POS_W'(MAX_PAGES);
  localparam logic [AW-1:0]              LAST_ADDR = AW'(MAX_PAGES - 1);
  localparam logic [RW-1:0]              PB_R      = RW'(PAGE_BYTES);
  localparam logic [ffpa_pkg::SIZE_W:0]  RECIP     =
    (ffpa_pkg::SIZE_W + 1)'((longint'(1) << DIV_SH) / longint'(PAGE_BYTES));
  localparam logic [DCNT_W-1:0]          DIV_LAST  = DCNT_W'(2);

  // reset image of the table: one free run over all pages but the last,
  // then a used sentinel
  localparam logic [ffpa_pkg::ENTRY_W-1:0] INIT_FIRST =
    {1'b0, ffpa_pkg::LEN_W'(MAX_PAGES - 1)};
  localparam logic [ffpa_pkg::ENTRY_W-1:0] INIT_SENT  = 16'h8000;

  // --------------------------------------------------------------------------
  // page table memory, one write and one registered read per cycle
  // --------------------------------------------------------------------------
  logic [ffpa_pkg::ENTRY_W-1:0] page_mem [MAX_PAGES];
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [ffpa_pkg::ENTRY_W-1:0] mem_wdata;
  logic [ffpa_pkg::ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= page_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // control and datapath registers
  // --------------------------------------------------------------------------
  ffpa_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    init_cnt_r, init_cnt_nxt;

  // page count: byte count, quotient estimate, remainder, step counter
  logic [ffpa_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [ffpa_pkg::SIZE_W-1:0] quo_r, quo_nxt;
  logic [RW-1:0]               rem_r, rem_nxt;
  logic [DCNT_W-1:0]           dcnt_r, dcnt_nxt;

  logic [ffpa_pkg::LEN_W-1:0]  need_r, need_nxt;      // pages asked for
  logic [ffpa_pkg::POS_W-1:0]  pos_r, pos_nxt;        // header now in rdata_r
  logic [ffpa_pkg::POS_W-1:0]  split_pos_r, split_pos_nxt;
  logic [ffpa_pkg::LEN_W-1:0]  len_r, len_nxt;        // split rest or freed run

  logic [ffpa_pkg::INDEX_W-1:0] res_idx_r, res_idx_nxt;
  ffpa_pkg::status_t            res_st_r, res_st_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [ffpa_pkg::INDEX_W-1:0] out_idx_r, out_idx_nxt;
  ffpa_pkg::status_t            out_st_r, out_st_nxt;

  // --------------------------------------------------------------------------
  // combinational helpers
  // --------------------------------------------------------------------------
  logic                        in_beat;
  logic [ffpa_pkg::SIZE_W-1:0] in_size;
  logic [ffpa_pkg::POS_W-1:0]  in_pos;

  logic                        hdr_used;
  logic [ffpa_pkg::LEN_W-1:0]  hdr_len;
  logic [ffpa_pkg::POS_W-1:0]  next_pos;   // pos_r plus run length just read
  logic [ffpa_pkg::POS_W-1:0]  need_end;   // pos_r plus requested pages

  logic [PROD_W-1:0]           recip_prod;
  logic [PROD_W-1:0]           recip_q;
  logic [BACK_W-1:0]           back_prod;
  logic [BACK_W-1:0]           rem_full;

  logic                        quo_high;
  logic [ffpa_pkg::POS_W-1:0]  need_sum;

  logic [ffpa_pkg::POS_W-1:0]  merge_sum;

  assign in_beat = in_tvalid & in_tready;
  assign in_size = in_tdata[ffpa_pkg::SIZE_W-1:0];
  assign in_pos  = {{(ffpa_pkg::POS_W - ffpa_pkg::INDEX_W){1'b0}},
                    in_tdata[ffpa_pkg::SIZE_W +: ffpa_pkg::INDEX_W]};

  assign hdr_used = rdata_r[ffpa_pkg::ENTRY_W-1];
  assign hdr_len  = rdata_r[ffpa_pkg::LEN_W-1:0];
  assign next_pos = pos_r + {1'b0, hdr_len};
  assign need_end = pos_r + {1'b0, need_r};

  // quotient estimate, then remainder against the estimate
  assign recip_prod = {{(PROD_W - ffpa_pkg::SIZE_W){1'b0}}, size_r}
                    * {{(PROD_W - ffpa_pkg::SIZE_W - 1){1'b0}}, RECIP};
  assign recip_q    = recip_prod >> DIV_SH;
  assign back_prod  = {{RW{1'b0}}, quo_r} * {{ffpa_pkg::SIZE_W{1'b0}}, PB_R};
  assign rem_full   = {{RW{1'b0}}, size_r} - back_prod;

  // page count rounded up; anything past the length field fails
  assign quo_high = |quo_r[ffpa_pkg::SIZE_W-1:ffpa_pkg::LEN_W];
  assign need_sum = {1'b0, quo_r[ffpa_pkg::LEN_W-1:0]}
                  + {{(ffpa_pkg::POS_W - 1){1'b0}}, (rem_r != '0)};

  assign merge_sum = {1'b0, len_r} + {1'b0, hdr_len};

  assign in_tready = (state_r == ffpa_pkg::S_IDLE);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    size_nxt      = size_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    need_nxt      = need_r;
    pos_nxt       = pos_r;
    split_pos_nxt = split_pos_r;
    len_nxt       = len_r;
    res_idx_nxt   = res_idx_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;

    mem_re    = 1'b0;
    mem_raddr = pos_r[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = pos_r[AW-1:0];
    mem_wdata = '0;

    unique case (state_r)
      ffpa_pkg::S_INIT: begin
        // clearing sweep after reset
        mem_we    = 1'b1;
        mem_waddr = init_cnt_r;
        if (init_cnt_r == '0) begin
          mem_wdata = INIT_FIRST;
        end else if (init_cnt_r == LAST_ADDR) begin
          mem_wdata = INIT_SENT;
        end else begin
          mem_wdata = '0;
        end
        init_cnt_nxt = init_cnt_r + AW'(1);
        if (init_cnt_r == LAST_ADDR) begin
          state_nxt = ffpa_pkg::S_IDLE;
        end
      end

      ffpa_pkg::S_IDLE: begin
        if (in_beat) begin
          if (!in_tuser) begin
            size_nxt  = in_size;
            dcnt_nxt  = '0;
            state_nxt = ffpa_pkg::S_DIV;
          end else if (in_pos >= LAST_POS) begin
            // sentinel or beyond the table
            res_idx_nxt = '0;
            res_st_nxt  = ffpa_pkg::ST_IGNORED;
            state_nxt   = ffpa_pkg::S_DONE;
          end else begin
            pos_nxt   = in_pos;
            mem_re    = 1'b1;
            mem_raddr = in_pos[AW-1:0];
            state_nxt = ffpa_pkg::S_FREAD;
          end
        end
      end

      ffpa_pkg::S_DIV: begin
        // estimate may be one low; the last step fixes it
        if (dcnt_r == '0) begin
          quo_nxt = recip_q[ffpa_pkg::SIZE_W-1:0];
        end else if (dcnt_r == DCNT_W'(1)) begin
          rem_nxt = rem_full[RW-1:0];
        end else if (rem_r >= PB_R) begin
          quo_nxt = quo_r + ffpa_pkg::SIZE_W'(1);
          rem_nxt = rem_r - PB_R;
        end
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DIV_LAST) begin
          state_nxt = ffpa_pkg::S_NEED;
        end
      end

      ffpa_pkg::S_NEED: begin
        // zero bytes and oversized counts never reach the walk
        if (quo_high || need_sum == '0 || need_sum[ffpa_pkg::POS_W-1]) begin
          res_idx_nxt = '0;
          res_st_nxt  = ffpa_pkg::ST_NOSPACE;
          state_nxt   = ffpa_pkg::S_DONE;
        end else begin
          need_nxt  = need_sum[ffpa_pkg::LEN_W-1:0];
          pos_nxt   = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = ffpa_pkg::S_WALK;
        end
      end

      ffpa_pkg::S_WALK: begin
        if (!hdr_used && hdr_len >= need_r) begin
          // first fit: mark the run used, split off the rest if it fits
          mem_we        = 1'b1;
          mem_waddr     = pos_r[AW-1:0];
          mem_wdata     = {1'b1, need_r};
          res_idx_nxt   = pos_r[ffpa_pkg::INDEX_W-1:0];
          res_st_nxt    = ffpa_pkg::ST_ALLOC;
          split_pos_nxt = need_end;
          len_nxt       = hdr_len - need_r;
          if (hdr_len > need_r && need_end < PAGES_POS) begin
            state_nxt = ffpa_pkg::S_SPLIT;
          end else begin
            state_nxt = ffpa_pkg::S_DONE;
          end
        end else if (hdr_len == '0 || next_pos >= LAST_POS) begin
          // broken chain or end of table
          res_idx_nxt = '0;
          res_st_nxt  = ffpa_pkg::ST_NOSPACE;
          state_nxt   = ffpa_pkg::S_DONE;
        end else begin
          pos_nxt   = next_pos;
          mem_re    = 1'b1;
          mem_raddr = next_pos[AW-1:0];
        end
      end

      ffpa_pkg::S_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = split_pos_r[AW-1:0];
        mem_wdata = {1'b0, len_r};
        state_nxt = ffpa_pkg::S_DONE;
      end

      ffpa_pkg::S_FREAD: begin
        res_idx_nxt = '0;
        if (!hdr_used) begin
          res_st_nxt = ffpa_pkg::ST_IGNORED;
          state_nxt  = ffpa_pkg::S_DONE;
        end else begin
          // clear the mark now, merge with the neighbor next cycle
          mem_we     = 1'b1;
          mem_waddr  = pos_r[AW-1:0];
          mem_wdata  = {1'b0, hdr_len};
          len_nxt    = hdr_len;
          res_st_nxt = ffpa_pkg::ST_FREED;
          if (next_pos < PAGES_POS) begin
            // a zero-length run reads its own stale header here; the merge
            // would write zero, which the write above already left
            mem_re    = 1'b1;
            mem_raddr = next_pos[AW-1:0];
            state_nxt = ffpa_pkg::S_FMERGE;
          end else begin
            state_nxt = ffpa_pkg::S_DONE;
          end
        end
      end

      ffpa_pkg::S_FMERGE: begin
        if (!hdr_used) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[AW-1:0];
          if (merge_sum[ffpa_pkg::POS_W-1]) begin
            mem_wdata = {1'b0, ffpa_pkg::LEN_MAX};
          end else begin
            mem_wdata = merge_sum;
          end
        end
        state_nxt = ffpa_pkg::S_DONE;
      end

      ffpa_pkg::S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_st_nxt    = res_st_r;
          state_nxt     = ffpa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ffpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffpa_pkg::S_INIT;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    need_r      <= need_nxt;
    pos_r       <= pos_nxt;
    split_pos_r <= split_pos_nxt;
    len_r       <= len_nxt;
    res_idx_r   <= res_idx_nxt;
    res_st_r    <= res_st_nxt;
    out_idx_r   <= out_idx_nxt;
    out_st_r    <= out_st_nxt;
  end

  // --------------------------------------------------------------------------
  // result channel
  // --------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - ffpa_pkg::INDEX_W){1'b0}}, out_idx_r};
  assign out_tuser  = out_st_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffpa_pkg::S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r != ffpa_pkg::S_IDLE))
    else $error("accepted request did not start");

  a_index_zero_unless_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ffpa_pkg::ST_ALLOC) |-> (out_tdata == '0))
    else $error("nonzero index on a failed or free result");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffpa_pkg::S_WALK) |-> (pos_r < LAST_POS && need_r != '0))
    else $error("walk outside the table or with zero pages");

  a_split_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffpa_pkg::S_SPLIT) |->
      ($past(state_r) == ffpa_pkg::S_WALK && split_pos_r < PAGES_POS))
    else $error("split write out of sequence or out of range");

endmodule
